FILE: hw/rtl/simplified_aes_block_cipher_assert.svh
// Assertion macros used by the S-AES top level.
`ifndef SIMPLIFIED_AES_BLOCK_CIPHER_ASSERT_SVH
`define SIMPLIFIED_AES_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SAES_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAES_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hw/rtl/saes_pkg.sv
// Types, tables and nibble functions for the S-AES block cipher.
`default_nettype none

package saes_pkg;

	typedef enum logic {
		CMD_ENC = 1'b0,
		CMD_DEC = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [15:0] k0;
		logic [15:0] k1;
		logic [15:0] k2;
	} round_keys_t;

	localparam logic [7:0] RCON1 = 8'h80;
	localparam logic [7:0] RCON2 = 8'h30;

	localparam logic [3:0] SBOX [16] = '{
		4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
		4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
	};
	localparam logic [3:0] INV_SBOX [16] = '{
		4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
		4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
	};

	// multiply by x in GF(16), poly x^4+x+1
	function automatic logic [3:0] gf_x(input logic [3:0] a);
		gf_x = {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
	endfunction

	function automatic logic [3:0] gf_mul2(input logic [3:0] a);
		gf_mul2 = gf_x(a);
	endfunction

	function automatic logic [3:0] gf_mul4(input logic [3:0] a);
		gf_mul4 = gf_x(gf_x(a));
	endfunction

	function automatic logic [3:0] gf_mul9(input logic [3:0] a);
		gf_mul9 = gf_x(gf_x(gf_x(a))) ^ a;
	endfunction

	function automatic logic [15:0] sub_word(input logic [15:0] w);
		sub_word = {SBOX[w[15:12]], SBOX[w[11:8]], SBOX[w[7:4]], SBOX[w[3:0]]};
	endfunction

	function automatic logic [15:0] inv_sub_word(input logic [15:0] w);
		inv_sub_word = {INV_SBOX[w[15:12]], INV_SBOX[w[11:8]],
			INV_SBOX[w[7:4]], INV_SBOX[w[3:0]]};
	endfunction

	// swap nibbles 1 and 3
	function automatic logic [15:0] shift_rows(input logic [15:0] w);
		shift_rows = {w[15:12], w[3:0], w[7:4], w[11:8]};
	endfunction

	// matrix [1 4; 4 1] per column
	function automatic logic [15:0] mix_cols(input logic [15:0] w);
		mix_cols = {
			w[15:12] ^ gf_mul4(w[11:8]),
			gf_mul4(w[15:12]) ^ w[11:8],
			w[7:4] ^ gf_mul4(w[3:0]),
			gf_mul4(w[7:4]) ^ w[3:0]
		};
	endfunction

	// matrix [9 2; 2 9] per column
	function automatic logic [15:0] inv_mix_cols(input logic [15:0] w);
		inv_mix_cols = {
			gf_mul9(w[15:12]) ^ gf_mul2(w[11:8]),
			gf_mul2(w[15:12]) ^ gf_mul9(w[11:8]),
			gf_mul9(w[7:4]) ^ gf_mul2(w[3:0]),
			gf_mul2(w[7:4]) ^ gf_mul9(w[3:0])
		};
	endfunction

	// rotate nibbles, substitute, add round constant
	function automatic logic [7:0] key_g(input logic [7:0] w, input logic [7:0] rcon);
		key_g = {SBOX[w[3:0]], SBOX[w[7:4]]} ^ rcon;
	endfunction

	function automatic round_keys_t expand_key(input logic [15:0] key);
		logic [7:0] w2;
		logic [7:0] w3;
		logic [7:0] w4;
		logic [7:0] w5;
		w2 = key[15:8] ^ key_g(key[7:0], RCON1);
		w3 = w2 ^ key[7:0];
		w4 = w2 ^ key_g(w3, RCON2);
		w5 = w4 ^ w3;
		expand_key.k0 = key;
		expand_key.k1 = {w2, w3};
		expand_key.k2 = {w4, w5};
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/simplified_aes_block_cipher.sv
// Top level of the Simplified AES block cipher: handshakes, pipeline, key register.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------
//  input   | in        | in_valid / in_ready | cmd, data_block
//  output  | out       | out_valid/out_ready | result_block
//  config  | in        | cfg_valid/cfg_ready | cipher_key
//
// One item per cycle sustained while out_ready stays high; the input register takes
// the item at the accept edge, then the cipher logic feeds the result register.
// arst_n clears both stage valid flags and loads the round keys of a zero key.
// A stalled output holds the result; the input register still takes one more
// item, and in_ready falls only when both stages are full and out_ready is low.
// Config writes are always taken; the round keys are expanded at the write.
`default_nettype none
`include "simplified_aes_block_cipher_assert.svh"

module simplified_aes_block_cipher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [15:0] data_block,
	// result items
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      result_block,
	// key register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cipher_key
);

	saes_pkg::round_keys_t rk;

	logic        valid_s1;
	logic        cmd_s1;
	logic [15:0] blk_s1;
	logic        valid_s2;
	logic [15:0] result_s2;
	logic        adv_s1;
	logic [15:0] core_result;

	// key register, expanded on write
	assign cfg_ready = 1'b1;

	saes_key_exp u_key_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_valid && cfg_ready),
		.key    (cipher_key),
		.rk     (rk)
	);

	// stage 1 moves on when the result register is free or being drained
	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			blk_s1 <= data_block;
		end
	end

	// all cipher work between the input register and the result register
	saes_core u_core (
		.cmd    (cmd_s1),
		.blk    (blk_s1),
		.rk     (rk),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			result_s2 <= core_result;
		end
	end

	assign out_valid    = valid_s2;
	assign result_block = result_s2;

	// checks
	`SAES_ASSERT_SAME(a_ready_only_full_stall, !in_ready, valid_s1 && valid_s2 && !out_ready, "in_ready low without a full stalled pipeline")
	`SAES_ASSERT_NEXT(a_s1_reaches_out, valid_s1 && adv_s1, out_valid, "item in stage 1 did not reach the output")
	`SAES_ASSERT_NEXT(a_key_loaded, cfg_valid && cfg_ready, rk.k0 == $past(cipher_key), "round key 0 does not match written key")
	`SAES_ASSERT_NEXT(a_stall_keeps_s1, valid_s1 && !adv_s1, valid_s1 && $stable(blk_s1), "stage 1 item lost during stall")

endmodule

`default_nettype wire

FILE: hw/rtl/saes_key_exp.sv
// Key register: expands the cipher key into round keys on each write.
`default_nettype none

module saes_key_exp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [15:0]        key,
	output saes_pkg::round_keys_t   rk
);

	saes_pkg::round_keys_t rk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rk_q <= saes_pkg::expand_key(16'h0000);
		end else if (wr_en) begin
			rk_q <= saes_pkg::expand_key(key);
		end
	end

	assign rk = rk_q;

endmodule

`default_nettype wire

FILE: hw/rtl/saes_core.sv
// Combinational S-AES encrypt/decrypt datapath for one block.
`default_nettype none

module saes_core (
	input  wire logic                  cmd,
	input  wire logic [15:0]           blk,
	input  wire saes_pkg::round_keys_t rk,
	output logic [15:0]                result
);

	logic [15:0] enc_r1;
	logic [15:0] enc_out;
	logic [15:0] dec_r1;
	logic [15:0] dec_out;

	// encrypt: full round then final round
	assign enc_r1  = saes_pkg::mix_cols(saes_pkg::shift_rows(saes_pkg::sub_word(blk ^ rk.k0)))
		^ rk.k1;
	assign enc_out = saes_pkg::shift_rows(saes_pkg::sub_word(enc_r1)) ^ rk.k2;

	// decrypt: inverse steps in reverse order
	assign dec_r1  = saes_pkg::inv_sub_word(saes_pkg::shift_rows(blk ^ rk.k2)) ^ rk.k1;
	assign dec_out = saes_pkg::inv_sub_word(saes_pkg::shift_rows(saes_pkg::inv_mix_cols(dec_r1)))
		^ rk.k0;

	assign result = (cmd == saes_pkg::CMD_DEC) ? dec_out : enc_out;

endmodule

`default_nettype wire
